[rtl/tcpq_pkg.sv]
// shared types and constants of the two-class priority queue
`default_nettype none

package tcpq_pkg;

  // fixed field widths
  localparam int unsigned ID_W  = 10;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned CNT_W = 5;

  // operation codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DEPART = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic search;
    logic apply;
  } ctrl_cmd_t;

  // one result item
  typedef struct packed {
    logic             ok;
    logic             found;
    logic [ID_W-1:0]  popped_id;
    logic [CNT_W-1:0] entry_count;
  } result_t;

endpackage

`default_nettype wire

[rtl/tcpq_ctrl.sv]
// controller state machine: sequences load, search and apply, owns output valid
`default_nettype none

module tcpq_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output tcpq_pkg::ctrl_cmd_t  cmd_o
);

  tcpq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcpq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    case (state_q)
      tcpq_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tcpq_pkg::ST_SEARCH;
        end
      end
      tcpq_pkg::ST_SEARCH: begin
        cmd_o.search = 1'b1;
        state_d      = tcpq_pkg::ST_APPLY;
      end
      tcpq_pkg::ST_APPLY: begin
        // wait until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.apply = 1'b1;
          out_valid_d = 1'b1;
          state_d     = tcpq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcpq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[rtl/tcpq_datapath.sv]
// datapath: request register, shifting entry cells, parallel compare and result register
`default_nettype none

module tcpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_ITEM_ID = 1023
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  tcpq_pkg::ctrl_cmd_t               cmd_i,
  input  wire                               cfg_we_i,
  input  wire                               cfg_class_i,
  input  tcpq_pkg::cmd_e                    req_cmd_i,
  input  wire [tcpq_pkg::ID_W-1:0]          req_id_i,
  input  wire                               req_class_i,
  input  wire                               req_urgent_i,
  output tcpq_pkg::result_t                 res_o
);

  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // request register
  tcpq_pkg::cmd_e              req_cmd_q;
  logic [tcpq_pkg::ID_W-1:0]   req_id_q;
  logic                        req_cls_q;
  logic                        req_urg_q;

  // configuration and counts
  logic                        qclass_q;
  logic [CntW-1:0]             occ_q, occ_d;
  logic [CntW-1:0]             ucnt_q, ucnt_d;

  // entry cells, head at index 0
  logic [tcpq_pkg::ID_W-1:0]   ids_q [QUEUE_DEPTH];
  logic [tcpq_pkg::ID_W-1:0]   ids_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]      urg_q, urg_d;

  // search results
  logic                        hit_q, hit_d;
  logic                        add_ok_q, add_ok_d;
  logic [CntW-1:0]             pos_q, pos_d;
  logic [tcpq_pkg::ID_W-1:0]   pid_q, pid_d;
  logic                        purg_q, purg_d;

  // compare results
  logic [QUEUE_DEPTH-1:0]      match;
  logic [IdxW-1:0]             enc;
  logic [tcpq_pkg::ID_W-1:0]   m_id;
  logic                        m_urg;
  logic                        legal;
  logic                        present;

  tcpq_pkg::result_t           res_q, res_d;

  // capture request on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_cmd_q <= req_cmd_i;
      req_id_q  <= req_id_i;
      req_cls_q <= req_class_i;
      req_urg_q <= req_urgent_i;
    end
  end

  // parallel compare across cells; ids are unique so the match is one-hot
  always_comb begin
    match = '0;
    enc   = '0;
    m_id  = '0;
    m_urg = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      match[i] = (CntW'(i) < occ_q) && (ids_q[i] == req_id_q);
      if (match[i]) begin
        enc   = enc | IdxW'(i);
        m_id  = m_id | ids_q[i];
        m_urg = m_urg | urg_q[i];
      end
    end
  end

  assign legal   = (req_id_q != '0) && (32'(req_id_q) <= MAX_ITEM_ID);
  assign present = legal && (|match);

  // search stage decisions
  always_comb begin
    hit_d    = present;
    pos_d    = CntW'(enc);
    pid_d    = m_id;
    purg_d   = m_urg;
    add_ok_d = legal && !present && (req_cls_q == qclass_q)
               && (occ_q < CntW'(QUEUE_DEPTH));
    case (req_cmd_q)
      tcpq_pkg::CMD_ADD: begin
        pos_d = req_urg_q ? ucnt_q : occ_q;
      end
      tcpq_pkg::CMD_DEPART: begin
        hit_d  = (occ_q != '0);
        pos_d  = '0;
        pid_d  = ids_q[0];
        purg_d = urg_q[0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      hit_q    <= hit_d;
      add_ok_q <= add_ok_d;
      pos_q    <= pos_d;
      pid_q    <= pid_d;
      purg_q   <= purg_d;
    end
  end

  // apply stage: shift cells, update counts, form result
  always_comb begin
    ids_d  = ids_q;
    urg_d  = urg_q;
    occ_d  = occ_q;
    ucnt_d = ucnt_q;
    res_d  = res_q;
    if (cmd_i.apply) begin
      res_d = '0;
      case (req_cmd_q)
        tcpq_pkg::CMD_ADD: begin
          res_d.ok = add_ok_q;
          if (add_ok_q) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
              if (CntW'(i) == pos_q) begin
                ids_d[i] = req_id_q;
                urg_d[i] = req_urg_q;
              end else if (i > 0 && CntW'(i) > pos_q) begin
                ids_d[i] = ids_q[(i > 0) ? i - 1 : 0];
                urg_d[i] = urg_q[(i > 0) ? i - 1 : 0];
              end
            end
            occ_d  = occ_q + CntW'(1);
            ucnt_d = ucnt_q + CntW'(req_urg_q);
          end
        end
        tcpq_pkg::CMD_REMOVE, tcpq_pkg::CMD_DEPART: begin
          res_d.ok = hit_q;
          if (hit_q) begin
            res_d.popped_id = pid_q;
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              if (CntW'(i) >= pos_q) begin
                ids_d[i] = ids_q[i + 1];
                urg_d[i] = urg_q[i + 1];
              end
            end
            occ_d  = occ_q - CntW'(1);
            ucnt_d = ucnt_q - CntW'(purg_q);
          end
        end
        tcpq_pkg::CMD_QUERY: begin
          res_d.ok    = 1'b1;
          res_d.found = hit_q;
        end
        default: begin
        end
      endcase
      res_d.entry_count = tcpq_pkg::CNT_W'(occ_d);
    end
  end

  // entry cells hold no reset value
  always_ff @(posedge clk_i) begin
    ids_q <= ids_d;
    urg_q <= urg_d;
    res_q <= res_d;
  end

  // counts and queue class
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      ucnt_q   <= '0;
      qclass_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      ucnt_q <= ucnt_d;
      if (cfg_we_i) begin
        qclass_q <= cfg_class_i;
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/two_class_priority_queue_core.sv]
// top level of the two-class priority queue with keyed removal
// result path: request register, then search register (search), then result register (apply)
// a new item is taken only in the idle state, once the load/search/apply sequence
//   of the controller is done; a stalled output register holds the apply step
// a new item is taken while the previous result waits in the output register
// reset: queue empty, queue class 0; entry cells are not cleared
`default_nettype none

module two_class_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MAX_ITEM_ID = 1023
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_data_i,     // queue_class
  // input stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire [15:0]  s_axis_tdata_i, // item_id[9:0], item_class[10], urgent[11], zero pad
  input  wire [1:0]   s_axis_tuser_i, // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o  // ok[0], found[1], popped_id[11:2],
                                      // entry_count[16:12], zero pad
);

  tcpq_pkg::ctrl_cmd_t ctrl_cmd;
  tcpq_pkg::result_t   res;

  assign cfg_ready_o = 1'b1;

  // controller
  tcpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (ctrl_cmd)
  );

  // datapath
  tcpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_ITEM_ID (MAX_ITEM_ID)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .cfg_we_i     (cfg_valid_i),
    .cfg_class_i  (cfg_data_i),
    .req_cmd_i    (tcpq_pkg::cmd_e'(s_axis_tuser_i)),
    .req_id_i     (s_axis_tdata_i[9:0]),
    .req_class_i  (s_axis_tdata_i[10]),
    .req_urgent_i (s_axis_tdata_i[11]),
    .res_o        (res)
  );

  // result packing
  assign m_axis_tdata_o = {7'd0, res.entry_count, res.popped_id, res.found, res.ok};

endmodule

`default_nettype wire
